FILE: rtl/wse_pkg.sv
// Package for the WSPR symbol encoder: code masks, message and slot counts,
// register indexes, state and command types, and the 8-bit reversal function.
// No dependencies.
`timescale 1ns / 1ps

package wse_pkg;

	localparam int unsigned MESSAGE_BITS = 50;
	localparam int unsigned SYMBOL_SLOTS = 162;
	localparam int unsigned FLUSH_BITS   = 31;

	localparam logic [31:0] POLY_A = 32'hf2d05351;
	localparam logic [31:0] POLY_B = 32'he4613c47;

	localparam int unsigned SYNC_LOW_W  = 64;
	localparam int unsigned SYNC_MID_W  = 64;
	localparam int unsigned SYNC_HIGH_W = 34;
	localparam int unsigned CFG_DATA_W  = 64;
	localparam int unsigned CFG_INDEX_W = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SYNC_LOW  = 2'd0,
		REG_SYNC_MID  = 2'd1,
		REG_SYNC_HIGH = 2'd2
	} wse_reg_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EMIT = 1'b1
	} wse_state_t;

	// One request from the coder to the interleaver.
	typedef struct packed {
		logic clear;
		logic step;
		logic coded;
	} wse_sym_cmd_t;

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7-i] = v[i];
		end
		return r;
	endfunction

endpackage

FILE: rtl/wse_msg_if.sv
// Input channel carrying one packed message bit and the start flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface wse_msg_if;
	logic valid;
	logic ready;
	logic message_bit;
	logic start_req;

	modport source (output valid, output message_bit, output start_req, input ready);
	modport sink (input valid, input message_bit, input start_req, output ready);
endinterface

FILE: rtl/wse_sym_if.sv
// Output channel carrying one interleaved channel symbol.
// Depends on nothing.
`timescale 1ns / 1ps

interface wse_sym_if;
	logic       valid;
	logic       ready;
	logic [7:0] position;
	logic [1:0] symbol;
	logic       last;

	modport source (output valid, output position, output symbol, output last, input ready);
	modport sink (input valid, input position, input symbol, input last, output ready);
endinterface

FILE: rtl/wse_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on wse_pkg for the field widths.
`timescale 1ns / 1ps

interface wse_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [wse_pkg::CFG_INDEX_W-1:0]    reg_index;
	logic [wse_pkg::CFG_DATA_W-1:0]     wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: rtl/wse_conv.sv
// Convolutional coder: 32-bit history shift register, two parity trees and
// the sequencer that steps out message and flush bits. Depends on wse_pkg
// and wse_msg_if.
`timescale 1ns / 1ps

module wse_conv (
	input  logic                  clk,
	input  logic                  arst_n,
	wse_msg_if.sink               msg,
	input  logic                  avail,
	output wse_pkg::wse_sym_cmd_t cmd
);
	import wse_pkg::*;

	wse_state_t  state_q, state_d;
	logic [31:0] hist_q;
	logic [5:0]  bits_q;
	logic        done_q;
	logic        phase_q;
	logic [4:0]  flush_q;

	logic        accept;
	logic        par_a, par_b;
	logic        done_eff;
	logic [31:0] hist_base;
	logic [5:0]  bits_next;
	logic        last_step;

	assign msg.ready = (state_q == ST_IDLE);
	assign accept    = msg.valid && msg.ready;
	assign par_a     = ^(hist_q & POLY_A);
	assign par_b     = ^(hist_q & POLY_B);
	assign done_eff  = msg.start_req ? 1'b0 : done_q;
	assign hist_base = msg.start_req ? 32'd0 : hist_q;
	assign bits_next = (msg.start_req ? 6'd0 : bits_q) + 6'd1;
	assign last_step = phase_q && (flush_q == 5'd0);

	always_comb begin
		state_d   = state_q;
		cmd.clear = 1'b0;
		cmd.step  = 1'b0;
		cmd.coded = phase_q ? par_b : par_a;
		unique case (state_q)
			ST_IDLE: begin
				cmd.clear = accept && msg.start_req;
				if (accept && !done_eff) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.step = avail;
				if (avail && last_step) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			bits_q  <= '0;
			done_q  <= 1'b1;
			phase_q <= 1'b0;
			flush_q <= '0;
		end else if (accept) begin
			if (!done_eff) begin
				hist_q  <= {hist_base[30:0], msg.message_bit};
				bits_q  <= bits_next;
				phase_q <= 1'b0;
				if (bits_next == 6'(MESSAGE_BITS)) begin
					flush_q <= 5'(FLUSH_BITS);
					done_q  <= 1'b1;
				end else begin
					flush_q <= '0;
					done_q  <= 1'b0;
				end
			end
		end else if (cmd.step) begin
			if (!phase_q) begin
				phase_q <= 1'b1;
			end else begin
				phase_q <= 1'b0;
				if (flush_q != 5'd0) begin
					hist_q  <= {hist_q[30:0], 1'b0};
					flush_q <= flush_q - 5'd1;
				end
			end
		end
	end

endmodule

FILE: rtl/wse_ilv.sv
// Interleaver and symbol mapper: reversal counter, sync vector registers and
// the output register. Depends on wse_pkg, wse_sym_if and wse_cfg_if.
`timescale 1ns / 1ps

module wse_ilv (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wse_pkg::wse_sym_cmd_t cmd,
	output logic                  avail,
	wse_cfg_if.sink               cfg,
	wse_sym_if.source             sym
);
	import wse_pkg::*;

	localparam int unsigned SYNC_W = SYNC_HIGH_W + SYNC_MID_W + SYNC_LOW_W;

	logic [SYNC_LOW_W-1:0]  sync_low_q;
	logic [SYNC_MID_W-1:0]  sync_mid_q;
	logic [SYNC_HIGH_W-1:0] sync_high_q;
	logic [SYNC_W-1:0]      sync_vec;

	logic [7:0] cnt_q;
	logic [7:0] sent_q;
	logic       out_valid_q;
	logic [7:0] pos_q;
	logic [1:0] symbol_q;
	logic       last_q;

	logic [7:0] rev_first;
	logic [7:0] rev_second;
	logic       first_ok;
	logic [7:0] pos_d;
	logic [7:0] sent_d;
	logic       cfg_wr;

	// Only odd counter values reverse to slots beyond the last, so one skip
	// is always enough to reach a valid slot.
	assign rev_first  = rev8(cnt_q);
	assign rev_second = rev8(cnt_q + 8'd1);
	assign first_ok   = rev_first < 8'(SYMBOL_SLOTS);
	assign pos_d      = first_ok ? rev_first : rev_second;
	assign sent_d     = sent_q + 8'd1;
	assign sync_vec   = {sync_high_q, sync_mid_q, sync_low_q};

	assign avail     = !out_valid_q || sym.ready;
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	assign sym.valid    = out_valid_q;
	assign sym.position = pos_q;
	assign sym.symbol   = symbol_q;
	assign sym.last     = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_low_q  <= '0;
			sync_mid_q  <= '0;
			sync_high_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg.reg_index)
				REG_SYNC_LOW:  sync_low_q  <= cfg.wdata;
				REG_SYNC_MID:  sync_mid_q  <= cfg.wdata;
				REG_SYNC_HIGH: sync_high_q <= cfg.wdata[SYNC_HIGH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			sent_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				cnt_q  <= '0;
				sent_q <= '0;
			end else if (cmd.step) begin
				cnt_q  <= cnt_q + (first_ok ? 8'd1 : 8'd2);
				sent_q <= sent_d;
			end
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (sym.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			pos_q    <= pos_d;
			symbol_q <= {cmd.coded, sync_vec[pos_d]};
			last_q   <= sent_d == 8'(SYMBOL_SLOTS);
		end
	end

endmodule

FILE: rtl/wspr_symbol_encoder_core.sv
// Channel   Direction  Payload
// msg       in         message_bit, start_req
// sym       out        position, symbol, last
// cfg       in         reg_index, wdata (sync vector words)
//
// Each accepted bit of an open message gives two symbols, one per cycle while
// sym does not stall, from the cycle after it is taken; the fiftieth bit gives
// 64 symbols. The input stays blocked until the last symbol of an item enters
// the output register.
// A stall on sym holds the output register and halts the coder in place.
// Reset leaves the block waiting for a start; the sync vector resets to zero.
// Top level of the WSPR symbol encoder. Depends on wse_pkg, the channel
// interfaces, wse_conv and wse_ilv.
`timescale 1ns / 1ps

module wspr_symbol_encoder_core (
	input  logic      clk,
	input  logic      arst_n,
	wse_msg_if.sink   msg,
	wse_sym_if.source sym,
	wse_cfg_if.sink   cfg
);
	import wse_pkg::*;

	wse_sym_cmd_t cmd;
	logic         avail;

	wse_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.avail  (avail),
		.cmd    (cmd)
	);

	wse_ilv u_ilv (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.avail  (avail),
		.cfg    (cfg),
		.sym    (sym)
	);

endmodule

FILE: tb/sv/wspr_symbol_encoder_core_tb.sv
// Self-checking testbench for wspr_symbol_encoder_core: drives message bits and sync words,
// predicts every interleaved channel symbol and compares each one as it leaves the block.
// Depends on wse_pkg and the wse_msg_if, wse_sym_if and wse_cfg_if interfaces.
`timescale 1ns / 1ps

module wspr_symbol_encoder_core_tb;
	import wse_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 10;
	localparam int BIT_TARGET   = 320;

	typedef struct packed {
		logic [7:0] position;
		logic [1:0] symbol;
		logic       last;
	} chan_symbol_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic no_idle = 1'b0;

	wse_msg_if msg_ch();
	wse_sym_if sym_ch();
	wse_cfg_if cfg_ch();

	wspr_symbol_encoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.sym    (sym_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state.
	logic [161:0] sync_vector;
	logic [31:0]  code_history;
	int unsigned  bits_in_msg;
	logic [7:0]   slot_counter;
	logic         msg_closed;
	int unsigned  symbols_in_msg;

	chan_symbol_t pending_symbols[$];
	chan_symbol_t due_symbol;
	chan_symbol_t seen_symbol;

	int mismatches;
	int bits_encoded;
	int bits_dropped;
	int symbols_checked;
	int messages_completed;
	int regs_written;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		sym_ch.ready <= no_idle || ($urandom_range(99) >= 10);
	end

	task automatic note_mismatch(input logic orphan, input chan_symbol_t want,
			input chan_symbol_t got);
		mismatches++;
		if (mismatches <= 10) begin
			if (orphan) begin
				$display("Mismatch: symbol with nothing expected, got position %0d symbol %0d last %0b",
					got.position, got.symbol, got.last);
			end else begin
				$display("Mismatch: expected position %0d symbol %0d last %0b, got position %0d symbol %0d last %0b",
					want.position, want.symbol, want.last, got.position, got.symbol, got.last);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && sym_ch.valid && sym_ch.ready) begin
			seen_symbol = '{sym_ch.position, sym_ch.symbol, sym_ch.last};
			symbols_checked++;
			if (pending_symbols.size() == 0) begin
				note_mismatch(1'b1, seen_symbol, seen_symbol);
			end else begin
				due_symbol = pending_symbols.pop_front();
				if (due_symbol != seen_symbol) begin
					note_mismatch(1'b0, due_symbol, seen_symbol);
				end else if (seen_symbol.last) begin
					messages_completed++;
				end
			end
		end
	end

	task automatic place_symbol(input logic coded);
		logic [7:0]   slot;
		chan_symbol_t next_sym;
		slot = 8'hff;
		while (slot >= SYMBOL_SLOTS) begin
			for (int i = 0; i < 8; i++) begin
				slot[7-i] = slot_counter[i];
			end
			slot_counter = slot_counter + 8'd1;
		end
		symbols_in_msg++;
		next_sym.position = slot;
		next_sym.symbol   = {coded, sync_vector[slot]};
		next_sym.last     = (symbols_in_msg == SYMBOL_SLOTS);
		pending_symbols.push_back(next_sym);
	endtask

	task automatic shift_code_bit(input logic bit_val);
		code_history = {code_history[30:0], bit_val};
		place_symbol(^(code_history & POLY_A));
		place_symbol(^(code_history & POLY_B));
	endtask

	task automatic encode_bit(input logic bit_val, input logic start_val, output logic took);
		if (start_val) begin
			code_history   = '0;
			bits_in_msg    = 0;
			slot_counter   = '0;
			msg_closed     = 1'b0;
			symbols_in_msg = 0;
		end
		took = !msg_closed;
		if (!msg_closed) begin
			shift_code_bit(bit_val);
			bits_in_msg++;
			if (bits_in_msg >= MESSAGE_BITS) begin
				repeat (FLUSH_BITS) shift_code_bit(1'b0);
				msg_closed = 1'b1;
			end
		end
	endtask

	task automatic send_bit(input logic bit_val, input logic start_val);
		logic took;
		while (!no_idle && $urandom_range(99) < 10) begin
			msg_ch.valid <= 1'b0;
			@(posedge clk);
		end
		msg_ch.valid       <= 1'b1;
		msg_ch.message_bit <= bit_val;
		msg_ch.start_req   <= start_val;
		do @(posedge clk); while (!msg_ch.ready);
		encode_bit(bit_val, start_val, took);
		if (took) begin
			bits_encoded++;
		end else begin
			bits_dropped++;
		end
	endtask

	task automatic wait_idle();
		msg_ch.valid <= 1'b0;
		while (pending_symbols.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [63:0] data,
			input logic more);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= index;
		cfg_ch.wdata     <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		if (!more) begin
			cfg_ch.valid <= 1'b0;
		end
		case (index)
			REG_SYNC_LOW: begin
				sync_vector[63:0] = data;
			end
			REG_SYNC_MID: begin
				sync_vector[127:64] = data;
			end
			REG_SYNC_HIGH: begin
				sync_vector[161:128] = data[SYNC_HIGH_W-1:0];
			end
			default: begin
			end
		endcase
		regs_written++;
	endtask

	task automatic test_wait_for_start();
		send_bit(1'b1, 1'b0);
		send_bit(1'b0, 1'b0);
		send_bit(1'b1, 1'b1);
		send_bit(1'b0, 1'b0);
		send_bit(1'b1, 1'b0);
		send_bit(1'b1, 1'b0);
	endtask

	task automatic test_restart_mid_message();
		send_bit(1'b0, 1'b1);
		send_bit(1'b1, 1'b0);
		send_bit(1'b1, 1'b1);
		send_bit(1'b0, 1'b0);
		wait_idle();
	endtask

	task automatic test_register_writes();
		write_reg(REG_SYNC_LOW, '1, 1'b1);
		write_reg(REG_SYNC_MID, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
		write_reg(REG_SYNC_HIGH, '1, 1'b1);
		write_reg(REG_UNUSED, 64'h5555_5555_5555_5555, 1'b0);
		send_bit(1'b1, 1'b1);
		send_bit(1'b1, 1'b0);
		send_bit(1'b0, 1'b0);
		send_bit(1'b1, 1'b0);
		wait_idle();
		write_reg(REG_SYNC_LOW, '0, 1'b1);
		write_reg(REG_SYNC_MID, '1, 1'b1);
		write_reg(REG_SYNC_HIGH, 64'h0000_0002_5555_5555, 1'b0);
	endtask

	task automatic test_random_messages();
		int msg_count;
		int cut_at;
		int noise;
		int pick;
		logic more_regs;
		msg_count = 0;
		while (bits_encoded < BIT_TARGET) begin
			// The third message runs with both sides never idling.
			no_idle = (msg_count == 2);
			if ($urandom_range(2) == 0) begin
				wait_idle();
				pick = $urandom_range(3);
				more_regs = $urandom_range(1);
				write_reg(REG_SYNC_LOW, (pick == 0) ? '0 : (pick == 1) ? '1 :
					{$urandom, $urandom}, 1'b1);
				write_reg(REG_SYNC_MID, (pick == 0) ? '1 : (pick == 1) ? '0 :
					{$urandom, $urandom}, 1'b1);
				write_reg(REG_SYNC_HIGH, (pick == 0) ? '0 : (pick == 1) ? '1 :
					{$urandom, $urandom}, more_regs);
				if (more_regs) begin
					write_reg(REG_UNUSED, {$urandom, $urandom}, 1'b0);
				end
			end
			cut_at = ($urandom_range(99) < 15) ? $urandom_range(1, MESSAGE_BITS - 2) : MESSAGE_BITS;
			send_bit($urandom_range(1), 1'b1);
			for (int n = 1; n < cut_at; n++) begin
				send_bit($urandom_range(1), 1'b0);
			end
			if (cut_at == MESSAGE_BITS) begin
				noise = $urandom_range(3);
				repeat (noise) send_bit($urandom_range(1), 1'b0);
			end
			msg_count++;
		end
		no_idle = 1'b0;
	endtask

	initial begin
		msg_ch.valid       <= 1'b0;
		msg_ch.message_bit <= 1'b0;
		msg_ch.start_req   <= 1'b0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.reg_index   <= REG_SYNC_LOW;
		cfg_ch.wdata       <= '0;
		sync_vector    = '0;
		code_history   = '0;
		bits_in_msg    = 0;
		slot_counter   = '0;
		msg_closed     = 1'b1;
		symbols_in_msg = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_wait_for_start();
		test_restart_mid_message();
		test_register_writes();
		test_random_messages();
		wait_idle();

		if (pending_symbols.size() != 0) begin
			mismatches++;
		end
		$display("Run covered %0d encoded and %0d dropped message bits, %0d register writes.",
			bits_encoded, bits_dropped, regs_written);
		$display("%0d symbols compared, %0d complete messages, %0d mismatches.",
			symbols_checked, messages_completed, mismatches);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
